### rtl/core/unicode_escape_decoder_macros.svh
`ifndef UNICODE_ESCAPE_DECODER_MACROS_SVH
`define UNICODE_ESCAPE_DECODER_MACROS_SVH

// Implication checked out of reset only.
`define UED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent, out of reset only.
`define UED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent at every edge, also during reset.
`define UED_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/ued_pkg.sv
`default_nettype none

package ued_pkg;

    localparam int UNIT_W = 16;

    localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] CH_U         = 16'h0075;
    localparam logic [UNIT_W-1:0] CH_T         = 16'h0074;
    localparam logic [UNIT_W-1:0] CH_R         = 16'h0072;
    localparam logic [UNIT_W-1:0] CH_N         = 16'h006E;
    localparam logic [UNIT_W-1:0] CH_F         = 16'h0066;
    localparam logic [UNIT_W-1:0] CH_0         = 16'h0030;
    localparam logic [UNIT_W-1:0] CH_9         = 16'h0039;
    localparam logic [UNIT_W-1:0] CH_LA        = 16'h0061;
    localparam logic [UNIT_W-1:0] CH_LF        = 16'h0066;
    localparam logic [UNIT_W-1:0] CH_UA        = 16'h0041;
    localparam logic [UNIT_W-1:0] CH_UF        = 16'h0046;

    localparam logic [UNIT_W-1:0] CTL_TAB = 16'h0009;
    localparam logic [UNIT_W-1:0] CTL_CR  = 16'h000D;
    localparam logic [UNIT_W-1:0] CTL_LF  = 16'h000A;
    localparam logic [UNIT_W-1:0] CTL_FF  = 16'h000C;

    localparam logic [1:0] LAST_SLOT = 2'd3;

    typedef enum logic [1:0] {
        PH_PLAIN  = 2'd0,
        PH_ESCAPE = 2'd1,
        PH_HEX    = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [1:0]        digits_seen;
        logic [UNIT_W-1:0] hex_value;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{phase: PH_PLAIN, digits_seen: 2'd0,
                                           hex_value: '0};

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_digit(input logic [UNIT_W-1:0] u);
        hex_digit_t d;
        logic [UNIT_W-1:0] diff;
        d = '{ok: 1'b0, value: 4'd0};
        diff = '0;
        if (u >= CH_0 && u <= CH_9)
        begin
            diff = u - CH_0;
            d = '{ok: 1'b1, value: diff[3:0]};
        end
        else if (u >= CH_LA && u <= CH_LF)
        begin
            diff = u - CH_LA + 16'd10;
            d = '{ok: 1'b1, value: diff[3:0]};
        end
        else if (u >= CH_UA && u <= CH_UF)
        begin
            diff = u - CH_UA + 16'd10;
            d = '{ok: 1'b1, value: diff[3:0]};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ued_step.sv
`default_nettype none

module ued_step
    import ued_pkg::*;
(
    input  wire dec_state_t        cur,
    input  wire logic [UNIT_W-1:0] code_unit,
    input  wire logic              end_of_text,
    output dec_state_t             nxt,
    output logic                   res_valid,
    output logic [UNIT_W-1:0]      res_unit
);

    hex_digit_t        digit;
    logic [UNIT_W-1:0] hex_acc;

    assign digit   = hex_digit(code_unit);
    assign hex_acc = digit.ok ? {cur.hex_value[UNIT_W-5:0], digit.value} : cur.hex_value;

    always_comb
    begin
        nxt = cur;
        unique case (cur.phase)
            PH_ESCAPE:
            begin
                if (code_unit == CH_U)
                    nxt = '{phase: PH_HEX, digits_seen: 2'd0, hex_value: '0};
                else
                    nxt.phase = PH_PLAIN;
            end
            PH_HEX:
            begin
                if (cur.digits_seen == LAST_SLOT)
                    nxt = STATE_RESET;
                else
                begin
                    nxt.digits_seen = cur.digits_seen + 2'd1;
                    nxt.hex_value   = hex_acc;
                end
            end
            default:
            begin
                if (code_unit == CH_BACKSLASH)
                    nxt.phase = PH_ESCAPE;
                else
                    nxt.phase = PH_PLAIN;
            end
        endcase
        if (end_of_text)
            nxt = STATE_RESET;
    end

    always_comb
    begin
        res_valid = 1'b0;
        res_unit  = code_unit;
        unique case (cur.phase)
            PH_ESCAPE:
            begin
                res_valid = (code_unit != CH_U);
                priority if (code_unit == CH_T)
                    res_unit = CTL_TAB;
                else if (code_unit == CH_R)
                    res_unit = CTL_CR;
                else if (code_unit == CH_N)
                    res_unit = CTL_LF;
                else if (code_unit == CH_F)
                    res_unit = CTL_FF;
                else
                    res_unit = code_unit;
            end
            PH_HEX:
            begin
                res_valid = (cur.digits_seen == LAST_SLOT);
                res_unit  = hex_acc;
            end
            default:
            begin
                res_valid = (code_unit != CH_BACKSLASH);
                res_unit  = code_unit;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/unicode_escape_decoder.sv
// Path: an accepted request waits in the input register; its decoded unit, if any, is
// then registered in the result register. Throughput: one request per cycle while the
// output is not stalled; the input register and the result register are joined by a
// single pass of decode logic, and the state updates once per request.
// Reset (rst_n low, asynchronous): both registers empty, decoder in plain text.
`default_nettype none

module unicode_escape_decoder
    import ued_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [UNIT_W-1:0] code_unit,
    input  wire logic              end_of_text,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [UNIT_W-1:0]      decoded_unit
);

    logic              req_valid_reg;
    logic              req_valid_next;
    logic [UNIT_W-1:0] req_unit_reg;
    logic              req_eot_reg;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic [UNIT_W-1:0] res_unit_reg;

    dec_state_t        step_state;
    logic              step_valid;
    logic [UNIT_W-1:0] step_unit;
    logic              advance;
    logic              take_in;

    ued_step u_step (
        .cur         (state_reg),
        .code_unit   (req_unit_reg),
        .end_of_text (req_eot_reg),
        .nxt         (step_state),
        .res_valid   (step_valid),
        .res_unit    (step_unit)
    );

    assign advance  = req_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (!in_stall)
            req_valid_next = in_valid;
        state_next = advance ? step_state : state_reg;
        res_valid_next = res_valid_reg;
        if (advance && step_valid)
            res_valid_next = 1'b1;
        else if (!out_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // hold the request while stalled
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            req_unit_reg <= code_unit;
            req_eot_reg  <= end_of_text;
        end
        if (advance && step_valid)
            res_unit_reg <= step_unit;
    end

    assign out_valid    = res_valid_reg;
    assign decoded_unit = res_unit_reg;

endmodule

`default_nettype wire

### rtl/core/ued_checker.sv
`default_nettype none
`include "unicode_escape_decoder_macros.svh"

module ued_checker
    import ued_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [UNIT_W-1:0] decoded_unit
);

    `UED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(decoded_unit))

    `UED_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

    `UED_ASSERT_IMPL(a_no_stall_when_empty, clk, rst_n, !out_valid, !in_stall)

    `UED_ASSERT_IMPL(a_rise_latency, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind unicode_escape_decoder ued_checker u_ued_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .decoded_unit (decoded_unit)
);

`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none

module tb_top
    import ued_pkg::*;
;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              last;
        logic              typed;
        logic              emits;
        logic [UNIT_W-1:0] value;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_PER_PHASE = 340;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [UNIT_W-1:0] code_unit = '0;
    logic              end_of_text = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [UNIT_W-1:0] decoded_unit;

    int in_idle_pct = 0;
    int out_idle_pct = 0;

    logic [UNIT_W-1:0] expected_units[$];
    int requests_sent = 0;
    int units_checked = 0;
    int text_ends = 0;
    int mismatches = 0;

    phase_t            dec_mode = PH_PLAIN;
    logic [1:0]        dec_slots = 2'd0;
    logic [UNIT_W-1:0] dec_acc = '0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'h0000,     1'b0, 1'b1, 1'b1, 16'h0000},
        '{16'hFFFF,     1'b1, 1'b1, 1'b1, 16'hFFFF},
        '{CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{CH_T,         1'b0, 1'b1, 1'b1, CTL_TAB},
        '{CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{CH_R,         1'b0, 1'b1, 1'b1, CTL_CR},
        '{CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{CH_N,         1'b0, 1'b1, 1'b1, CTL_LF},
        '{CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{CH_F,         1'b0, 1'b1, 1'b1, CTL_FF},
        '{CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{16'hFFFF,     1'b0, 1'b1, 1'b1, 16'hFFFF},
        '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{CH_U,         1'b0, 1'b0, 1'b0, 16'h0000},
        '{CH_LF,        1'b0, 1'b0, 1'b0, 16'h0000},
        '{16'h0131,     1'b0, 1'b0, 1'b0, 16'h0000},
        '{CH_UA,        1'b0, 1'b0, 1'b0, 16'h0000},
        '{CH_9,         1'b1, 1'b0, 1'b0, 16'h0000},
        '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{CH_U,         1'b0, 1'b0, 1'b0, 16'h0000},
        '{CH_0,         1'b0, 1'b0, 1'b0, 16'h0000},
        '{16'h0034,     1'b1, 1'b0, 1'b0, 16'h0000},
        '{16'h0031,     1'b0, 1'b1, 1'b1, 16'h0031},
        '{CH_BACKSLASH, 1'b1, 1'b1, 1'b0, 16'h0000},
        '{CH_U,         1'b0, 1'b1, 1'b1, CH_U}
    };

    unicode_escape_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_unit    (code_unit),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .decoded_unit (decoded_unit)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge clk)
    begin
        logic [UNIT_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            units_checked++;
            if (expected_units.size() == 0)
            begin
                $error("decoded_unit: expected none, actual %h", decoded_unit);
                mismatches++;
            end
            else
            begin
                want = expected_units.pop_front();
                if (decoded_unit !== want)
                begin
                    $error("decoded_unit: expected %h, actual %h", want, decoded_unit);
                    mismatches++;
                end
            end
        end
    end

    function automatic logic [4:0] digit_of(input logic [UNIT_W-1:0] u);
        if (u >= CH_0 && u <= CH_9)
            return {1'b1, 4'(u - CH_0)};
        if (u >= CH_LA && u <= CH_LF)
            return {1'b1, 4'(u - CH_LA + 16'd10)};
        if (u >= CH_UA && u <= CH_UF)
            return {1'b1, 4'(u - CH_UA + 16'd10)};
        return 5'd0;
    endfunction

    function automatic void decode_step(input logic [UNIT_W-1:0] u, input logic last,
                                        output bit emits, output logic [UNIT_W-1:0] value);
        logic [4:0] d;
        emits = 1'b0;
        value = '0;
        case (dec_mode)
            PH_ESCAPE:
            begin
                if (u == CH_U)
                begin
                    dec_mode = PH_HEX;
                    dec_slots = 2'd0;
                    dec_acc = '0;
                end
                else
                begin
                    emits = 1'b1;
                    dec_mode = PH_PLAIN;
                    case (u)
                        CH_T:    value = CTL_TAB;
                        CH_R:    value = CTL_CR;
                        CH_N:    value = CTL_LF;
                        CH_F:    value = CTL_FF;
                        default: value = u;
                    endcase
                end
            end
            PH_HEX:
            begin
                d = digit_of(u);
                if (d[4])
                    dec_acc = {dec_acc[UNIT_W-5:0], d[3:0]};
                if (dec_slots == LAST_SLOT)
                begin
                    emits = 1'b1;
                    value = dec_acc;
                    dec_mode = PH_PLAIN;
                    dec_slots = 2'd0;
                    dec_acc = '0;
                end
                else
                    dec_slots = dec_slots + 2'd1;
            end
            default:
            begin
                if (u == CH_BACKSLASH)
                    dec_mode = PH_ESCAPE;
                else
                begin
                    emits = 1'b1;
                    value = u;
                    dec_mode = PH_PLAIN;
                end
            end
        endcase
        if (last)
        begin
            dec_mode = PH_PLAIN;
            dec_slots = 2'd0;
            dec_acc = '0;
        end
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_unit(input logic [UNIT_W-1:0] u, input logic last,
                             input bit typed, input bit t_emits,
                             input logic [UNIT_W-1:0] t_value);
        bit                emits;
        logic [UNIT_W-1:0] value;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        code_unit <= u;
        end_of_text <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_step(u, last, emits, value);
        if (typed)
        begin
            emits = t_emits;
            value = t_value;
        end
        if (emits)
            expected_units.push_back(value);
        requests_sent++;
        if (last)
            text_ends++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_units.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic random_last();
        return ($urandom_range(39) == 0);
    endfunction

    function automatic logic [UNIT_W-1:0] hex_char();
        int d;
        d = $urandom_range(21);
        if (d < 10)
            return CH_0 + UNIT_W'(d);
        if (d < 16)
            return CH_LA + UNIT_W'(d - 10);
        return CH_UA + UNIT_W'(d - 16);
    endfunction

    function automatic logic [UNIT_W-1:0] slot_unit();
        int                pick;
        logic [UNIT_W-1:0] low_char;
        pick = $urandom_range(9);
        if (pick < 8)
            return hex_char();
        if (pick == 8)
            return UNIT_W'($urandom);
        // high byte set over a hex-looking low byte
        low_char = hex_char();
        return {8'($urandom_range(255, 1)), low_char[7:0]};
    endfunction

    function automatic logic [UNIT_W-1:0] escape_letter();
        case ($urandom_range(5))
            0:       return CH_T;
            1:       return CH_R;
            2:       return CH_N;
            3:       return CH_F;
            4:       return CH_BACKSLASH;
            default: return UNIT_W'($urandom);
        endcase
    endfunction

    task automatic emit_sequence();
        int                pick;
        int                slots;
        int                k;
        logic [UNIT_W-1:0] u;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            if ($urandom_range(1))
                u = UNIT_W'($urandom);
            else
                u = UNIT_W'($urandom_range(16'h007E, 16'h0020));
            send_unit(u, random_last(), 1'b0, 1'b0, '0);
        end
        else if (pick < 55)
        begin
            send_unit(CH_BACKSLASH, 1'b0, 1'b0, 1'b0, '0);
            send_unit(escape_letter(), random_last(), 1'b0, 1'b0, '0);
        end
        else if (pick < 90)
        begin
            send_unit(CH_BACKSLASH, 1'b0, 1'b0, 1'b0, '0);
            send_unit(CH_U, 1'b0, 1'b0, 1'b0, '0);
            for (k = 0; k < 4; k++)
                send_unit(slot_unit(), (k == 3) && random_last(), 1'b0, 1'b0, '0);
        end
        else if ($urandom_range(3) == 0)
            send_unit(CH_BACKSLASH, 1'b1, 1'b0, 1'b0, '0);
        else
        begin
            // cut the escape short with the end of the text
            slots = $urandom_range(3);
            send_unit(CH_BACKSLASH, 1'b0, 1'b0, 1'b0, '0);
            send_unit(CH_U, slots == 0, 1'b0, 1'b0, '0);
            for (k = 1; k <= slots; k++)
                send_unit(slot_unit(), k == slots, 1'b0, 1'b0, '0);
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = requests_sent + count;
        while (requests_sent < target)
            emit_sequence();
    endtask

    initial
    begin
        int i;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        in_idle_pct = 26;
        out_idle_pct = 87;
        @(negedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_unit(directed_rows[i].unit, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].emits, directed_rows[i].value);
        drain_results();

        run_random(RANDOM_PER_PHASE);
        drain_results();
        in_idle_pct = 87;
        out_idle_pct = 26;
        run_random(RANDOM_PER_PHASE);
        drain_results();
        in_idle_pct = 0;
        out_idle_pct = 0;
        run_random(RANDOM_PER_PHASE);
        drain_results();
        repeat (10) @(posedge clk);

        if (expected_units.size() != 0)
        begin
            $error("decoded_unit: %0d expected units never arrived", expected_units.size());
            mismatches++;
        end
        $display("Decoder run: %0d requests (%0d directed), %0d with end of text marked",
                 requests_sent, DIRECTED_ROWS, text_ends);
        $display("Decoder run: %0d decoded units checked, %0d mismatches",
                 units_checked, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/ued_pkg.sv
rtl/core/ued_step.sv
rtl/core/unicode_escape_decoder.sv
rtl/core/ued_checker.sv
tb/sv/tb_top.sv
